FILE: rtl/core/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

	// Width kept for absolute offsets before they are cut to 32 bits.
	localparam int OFFSET_BITS = 32;
	localparam int OFF_KEEP = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
	localparam logic [31:0] OFF_MASK = 32'((64'd1 << OFF_KEEP) - 64'd1);

	localparam logic [31:0] MIN_BOX = 32'd8;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Configuration register indexes.
	localparam logic [1:0] REG_TARGET_TYPE = 2'd0;
	localparam logic [1:0] REG_REGION_BASE = 2'd1;
	localparam logic [1:0] REG_REGION_SIZE = 2'd2;

	typedef enum logic [1:0] {
		KIND_MATCH = 2'd0,
		KIND_STOP  = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] offset;
		logic [31:0] size;
		logic [15:0] count;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/cbs_core.sv
`default_nettype none

module cbs_core
	import cbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        beat_valid,
	input  wire logic [7:0]  beat_byte,
	input  wire logic        beat_start,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             res_valid,
	output res_t             res
);

	typedef enum logic [1:0] {
		PH_PARENT = 2'd0,
		PH_SIZE   = 2'd1,
		PH_TYPE   = 2'd2,
		PH_BODY   = 2'd3
	} phase_t;

	logic [31:0] target_type_q, region_base_q, region_size_q;

	phase_t      phase_q, phase_e, phase_n;
	logic [31:0] pos_q, pos_e, pos_n;
	logic        ovf_q, ovf_e, ovf_n;
	logic [1:0]  fbc_q, fbc_e, fbc_n;
	logic [31:0] size_q, size_e, size_n;
	logic [31:0] type_q, type_e, type_n;
	logic [31:0] skip_q, skip_e, skip_n;
	logic [31:0] bstart_q, bstart_e, bstart_n;
	logic [15:0] cnt_q, cnt_e, cnt_n;
	logic        pend_q, pend_e, pend_n;
	logic        halted_q, halted_e, halted_n;

	logic [32:0] pos_inc;
	logic        reached;
	logic        boundary;
	logic        matched;
	logic [31:0] type_new;
	logic [31:0] abs_off;

	always_comb begin
		// A region start clears the scan before the beat is processed.
		pos_e    = beat_start ? '0 : pos_q;
		ovf_e    = beat_start ? 1'b0 : ovf_q;
		phase_e  = beat_start ? PH_PARENT : phase_q;
		fbc_e    = beat_start ? '0 : fbc_q;
		size_e   = beat_start ? '0 : size_q;
		type_e   = beat_start ? '0 : type_q;
		skip_e   = beat_start ? '0 : skip_q;
		bstart_e = beat_start ? '0 : bstart_q;
		cnt_e    = beat_start ? '0 : cnt_q;
		pend_e   = beat_start ? 1'b0 : pend_q;
		halted_e = beat_start ? 1'b0 : halted_q;

		pos_n    = pos_e;
		ovf_n    = ovf_e;
		phase_n  = phase_e;
		fbc_n    = fbc_e;
		size_n   = size_e;
		type_n   = type_e;
		skip_n   = skip_e;
		bstart_n = bstart_e;
		cnt_n    = cnt_e;
		pend_n   = pend_e;
		halted_n = halted_e;

		pos_inc  = {1'b0, pos_e} + 33'd1;
		reached  = ovf_e | pos_inc[32] | (pos_inc[31:0] >= region_size_q);
		boundary = 1'b0;
		matched  = 1'b0;
		type_new = {type_e[23:0], beat_byte};
		abs_off  = (region_base_q + bstart_e) & OFF_MASK;

		res_valid = 1'b0;
		res       = '{kind: KIND_MATCH, offset: '0, size: '0, count: cnt_e};

		if (halted_e) begin
			// Idle until the next region start.
		end else if (pend_e) begin
			pend_n    = 1'b0;
			halted_n  = 1'b1;
			res_valid = 1'b1;
			res       = '{kind: KIND_END, offset: '0, size: '0, count: cnt_e};
		end else begin
			pos_n = pos_inc[31:0];
			ovf_n = ovf_e | pos_inc[32];
			case (phase_e)
				PH_PARENT: begin
					boundary = ovf_e || (pos_e >= (MIN_BOX - 32'd1));
				end
				PH_SIZE: begin
					if (fbc_e == 2'd0) begin
						bstart_n = pos_e;
					end
					size_n = {size_e[23:0], beat_byte};
					if (fbc_e == 2'd3) begin
						fbc_n   = '0;
						phase_n = PH_TYPE;
					end else begin
						fbc_n = fbc_e + 2'd1;
					end
				end
				PH_TYPE: begin
					type_n = type_new;
					if (fbc_e != 2'd3) begin
						fbc_n = fbc_e + 2'd1;
					end else begin
						fbc_n = '0;
						if (size_e < MIN_BOX) begin
							// A bad size wins over a type match and halts the scan.
							halted_n  = 1'b1;
							res_valid = 1'b1;
							res       = '{kind: KIND_STOP, offset: abs_off, size: size_e,
								count: cnt_e};
						end else begin
							if (type_new == target_type_q) begin
								matched = 1'b1;
								if (cnt_e != COUNT_MAX) begin
									cnt_n = cnt_e + 16'd1;
								end
								res_valid = 1'b1;
								res       = '{kind: KIND_MATCH, offset: abs_off, size: size_e,
									count: cnt_n};
							end
							if (size_e == MIN_BOX) begin
								boundary = 1'b1;
							end else begin
								skip_n  = size_e - MIN_BOX;
								phase_n = PH_BODY;
							end
						end
					end
				end
				default: begin
					skip_n   = (skip_e != '0) ? skip_e - 32'd1 : '0;
					boundary = (skip_n == '0);
				end
			endcase

			if (boundary) begin
				phase_n = PH_SIZE;
				fbc_n   = '0;
				if (reached) begin
					if (matched) begin
						// The end result follows on the next beat.
						pend_n = 1'b1;
					end else begin
						halted_n  = 1'b1;
						res_valid = 1'b1;
						res       = '{kind: KIND_END, offset: '0, size: '0, count: cnt_e};
					end
				end
			end
		end

		res_valid = res_valid & beat_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_type_q <= '0;
			region_base_q <= '0;
			region_size_q <= '0;
			phase_q       <= PH_PARENT;
			pos_q         <= '0;
			ovf_q         <= 1'b0;
			fbc_q         <= '0;
			size_q        <= '0;
			type_q        <= '0;
			skip_q        <= '0;
			bstart_q      <= '0;
			cnt_q         <= '0;
			pend_q        <= 1'b0;
			halted_q      <= 1'b1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TARGET_TYPE: target_type_q <= cfg_data;
					REG_REGION_BASE: region_base_q <= cfg_data;
					REG_REGION_SIZE: region_size_q <= cfg_data;
					default: ;
				endcase
			end
			if (beat_valid) begin
				phase_q  <= phase_n;
				pos_q    <= pos_n;
				ovf_q    <= ovf_n;
				fbc_q    <= fbc_n;
				size_q   <= size_n;
				type_q   <= type_n;
				skip_q   <= skip_n;
				bstart_q <= bstart_n;
				cnt_q    <= cnt_n;
				pend_q   <= pend_n;
				halted_q <= halted_n;
			end
		end
	end

	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_STOP) |=> halted_q)
		else $error("scan did not halt after a stop result");

	a_pend_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && halted_q))
		else $error("pending end while halted");

	a_fbc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PARENT) || (phase_q == PH_BODY) |-> (fbc_q == 2'd0))
		else $error("field byte count not cleared outside header fields");

endmodule

`default_nettype wire

FILE: rtl/core/cbs_out_buf.sv
`default_nettype none

module cbs_out_buf
	import cbs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  res_t      push_data,
	output logic      full,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_data
);

	res_t       mem_q [2];
	logic       rd_q;
	logic [1:0] count_q;
	logic       pop;
	logic       wr;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && out_ready;
	assign wr        = rd_q ^ count_q[0];
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("result pushed into a full buffer");

endmodule

`default_nettype wire

FILE: rtl/core/container_box_scanner.sv
`default_nettype none
// Channel | Dir | Fields (low bit first)
// s_*     | in  | tdata: stream_byte[7:0]; tuser: region_start
// m_*     | out | tdata: box_offset[31:0], box_size[31:0], boxes_found[15:0];
//         |     | tuser: result_kind[1:0]
// cfg_*   | in  | cfg_index selects target_type, region_base, region_size
//
// One beat enters per clock unless the input side stalls. A beat is held in the
// input register, and the scan logic then updates the state and, for at most
// one result per beat, writes the two-entry result buffer. The input side
// stalls only while the result buffer is full and not being drained. Reset
// clears the handshake state and leaves the scanner halted until a beat with
// region_start arrives.

module container_box_scanner
	import cbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // stream_byte
	input  wire logic        s_tuser,  // region_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,  // box_offset, box_size, boxes_found
	output logic [1:0]       m_tuser,  // result_kind
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       advance;
	logic       buf_full;
	logic       res_valid;
	res_t       res;
	res_t       out_res;

	// The held beat moves on whenever the buffer has room, counting a slot
	// freed by a result leaving in the same cycle.
	assign advance  = valid_s1 && (!buf_full || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	cbs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (advance),
		.beat_byte  (byte_s1),
		.beat_start (start_s1),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_valid  (res_valid),
		.res        (res)
	);

	cbs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {out_res.count, out_res.size, out_res.offset};
	assign m_tuser = out_res.kind;

	a_push_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> advance)
		else $error("result produced without a consumed beat");

endmodule

`default_nettype wire
